[design/ctd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants of the chunked transfer decoder
// Parse phases, result status codes, stage payload structs and hex decode.
// ----------------------------------------------------------------------------
package ctd_pkg;

  // Default limit on hex digits in one size line
  localparam int unsigned LEN_DIGITS = 8;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SIZE   = 3'd1,
    PH_LF     = 3'd2,
    PH_DATA   = 3'd3,
    PH_TRAIL1 = 3'd4,
    PH_TRAIL2 = 3'd5,
    PH_IDLE   = 3'd6
  } ctd_phase_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } ctd_status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_body;
  } ctd_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_chunk;
    ctd_status_e status;
  } ctd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } ctd_hex_t;

  // Decode one ASCII hex digit; ok is low for anything else
  function automatic ctd_hex_t hex_decode(logic [7:0] c);
    ctd_hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[design/ctd_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_in_if / ctd_out_if: valid/ready channels of the decoder
// Raw body bytes come in on ctd_in_if; decoded results leave on ctd_out_if.
// ----------------------------------------------------------------------------
interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_body;

  modport source (output valid, in_byte, start_of_body, input ready);
  modport sink   (input valid, in_byte, start_of_body, output ready);
endinterface

interface ctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_chunk;
  logic [1:0] status;

  modport source (output valid, out_byte, last_of_chunk, status, input ready);
  modport sink   (input valid, out_byte, last_of_chunk, status, output ready);
endinterface

[design/ctd_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_in_reg: input register stage
// Captures one accepted byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module ctd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctd_in_if.sink            in_i,
  input  logic              advance_i,
  output logic              valid_o,
  output ctd_pkg::ctd_item_t item_o
);

  logic               valid_q, valid_d;
  ctd_pkg::ctd_item_t item_q;
  logic               take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.in_byte       <= in_i.in_byte;
      item_q.start_of_body <= in_i.start_of_body;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[design/ctd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_parser: chunk framing state and per-byte step logic
// Updates the parse state for one byte per step and forms at most one result.
// ----------------------------------------------------------------------------
module ctd_parser #(
  parameter int unsigned LenDigits = ctd_pkg::LEN_DIGITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ctd_pkg::ctd_item_t   item_i,
  output logic                 res_valid_o,
  output ctd_pkg::ctd_result_t res_o
);

  ctd_pkg::ctd_phase_e phase_q, phase_d, phase_cur;
  logic [31:0]         remain_q, remain_d, remain_cur, remain_dec;
  logic [3:0]          digits_q, digits_d, digits_cur;
  logic                final_q, final_d, final_cur;
  ctd_pkg::ctd_hex_t   hex;
  logic [7:0]          c;

  assign c          = item_i.in_byte;
  assign hex        = ctd_pkg::hex_decode(c);
  assign remain_dec = remain_cur - 32'd1;

  // start mark restarts the parser before this byte is parsed
  always_comb begin
    phase_cur  = phase_q;
    remain_cur = remain_q;
    digits_cur = digits_q;
    final_cur  = final_q;
    if (item_i.start_of_body) begin
      phase_cur  = ctd_pkg::PH_FIRST;
      remain_cur = '0;
      digits_cur = '0;
      final_cur  = 1'b0;
    end
  end

  always_comb begin
    phase_d              = phase_cur;
    remain_d             = remain_cur;
    digits_d             = digits_cur;
    final_d              = final_cur;
    res_valid_o          = 1'b0;
    res_o.out_byte       = '0;
    res_o.last_of_chunk  = 1'b0;
    res_o.status         = ctd_pkg::ST_DATA;
    case (phase_cur)
      ctd_pkg::PH_FIRST: begin
        if (!hex.ok) begin
          phase_d      = ctd_pkg::PH_IDLE;
          res_valid_o  = 1'b1;
          res_o.status = ctd_pkg::ST_ERROR;
        end else begin
          remain_d = {28'd0, hex.value};
          digits_d = 4'd1;
          phase_d  = ctd_pkg::PH_SIZE;
        end
      end
      ctd_pkg::PH_SIZE: begin
        if (c == ctd_pkg::CHAR_CR) begin
          phase_d = ctd_pkg::PH_LF;
        end else if (!hex.ok || (digits_cur >= 4'(LenDigits))) begin
          phase_d      = ctd_pkg::PH_IDLE;
          res_valid_o  = 1'b1;
          res_o.status = ctd_pkg::ST_ERROR;
        end else begin
          // saturate a size that overflows 32 bits
          if (remain_cur > 32'h0FFF_FFFF) begin
            remain_d = 32'hFFFF_FFFF;
          end else begin
            remain_d = {remain_cur[27:0], hex.value};
          end
          digits_d = digits_cur + 4'd1;
        end
      end
      ctd_pkg::PH_LF: begin
        if (c != ctd_pkg::CHAR_LF) begin
          phase_d      = ctd_pkg::PH_IDLE;
          res_valid_o  = 1'b1;
          res_o.status = ctd_pkg::ST_ERROR;
        end else if (remain_cur == '0) begin
          final_d = 1'b1;
          phase_d = ctd_pkg::PH_TRAIL1;
        end else begin
          phase_d = ctd_pkg::PH_DATA;
        end
      end
      ctd_pkg::PH_DATA: begin
        remain_d       = remain_dec;
        res_valid_o    = 1'b1;
        res_o.out_byte = c;
        if (remain_dec == '0) begin
          res_o.last_of_chunk = 1'b1;
          phase_d             = ctd_pkg::PH_TRAIL1;
        end
      end
      ctd_pkg::PH_TRAIL1: begin
        phase_d = ctd_pkg::PH_TRAIL2;
      end
      ctd_pkg::PH_TRAIL2: begin
        if (final_cur) begin
          phase_d      = ctd_pkg::PH_IDLE;
          res_valid_o  = 1'b1;
          res_o.status = ctd_pkg::ST_END;
        end else begin
          phase_d  = ctd_pkg::PH_FIRST;
          remain_d = '0;
          digits_d = '0;
        end
      end
      default: begin
        phase_d = ctd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ctd_pkg::PH_FIRST;
      remain_q <= '0;
      digits_q <= '0;
      final_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      digits_q <= digits_d;
      final_q  <= final_d;
    end
  end

endmodule

[design/ctd_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_out_reg: result register stage
// Holds one result until the receiver takes it; loads the next in the same cycle.
// ----------------------------------------------------------------------------
module ctd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  ctd_pkg::ctd_result_t res_i,
  output logic                 ready_o,
  ctd_out_if.source            out_o
);

  logic                 valid_q, valid_d;
  ctd_pkg::ctd_result_t res_q;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = res_q.out_byte;
  assign out_o.last_of_chunk = res_q.last_of_chunk;
  assign out_o.status        = res_q.status;

endmodule

[design/chunked_transfer_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder: HTTP chunked body decoder, one byte per cycle
//
// Feed the raw chunked body on in_i, one byte per transaction, with
// start_of_body set on the first byte of each body. Results leave on out_o:
// status 0 carries a payload byte (last_of_chunk marks the final byte of a
// chunk), status 1 reports the end of the body after the zero chunk's two
// trailing bytes, status 2 reports a format error. Size-line bytes, CR LF and
// trailing bytes make no transaction on out_o except an end or error status.
//
// Throughput is one byte per cycle while the receiver does not stall.
// Each byte lands in the input register; the parser then steps and its
// result lands in the result register.
// Reset clears both stage valid flags and puts the parser at the first size
// digit. When the receiver stalls, the result register holds, then the input
// register fills, and in_i.ready drops; nothing is lost or repeated.
// After an end or error status, bytes are consumed silently until the next
// start_of_body.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
  parameter int unsigned LEN_DIGITS = ctd_pkg::LEN_DIGITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctd_in_if.sink    in_i,
  ctd_out_if.source out_o
);

  logic                 s1_valid;
  ctd_pkg::ctd_item_t   s1_item;
  logic                 out_ready;
  logic                 advance;
  logic                 res_valid;
  ctd_pkg::ctd_result_t res;

  // advance the held byte once the result register can take its outcome
  assign advance = s1_valid && out_ready;

  ctd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  ctd_parser #(
    .LenDigits (LEN_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ctd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_o       (out_o)
  );

endmodule
